[design/assert_macros.svh]
// Assertion macros used by the checker file stbs_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is high.
`define STBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define STBS_NEVER(label, clk, rst, cond, msg) \
   `STBS_ASSERT(label, clk, rst, !(cond), msg)

`endif

[design/stbs_pkg.sv]
// Package for the sorted table binary search block: word types, codes, constants.
// Depends on nothing; used by every module of the block.
package stbs_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int IDX_W           = 10;
   localparam int CNT_W           = 11;
   localparam int VAL_W           = 32;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [IDX_W-1:0]          write_index;
      logic signed [VAL_W-1:0]   entry_value;
      logic signed [VAL_W-1:0]   search_key;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [IDX_W-1:0]          match_index;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic write_entry;
      logic load_search;
      logic issue_read;
      logic emit_miss;
      logic emit_hit;
      logic go_left;
      logic go_right;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic range_open;
      logic key_lt;
      logic key_eq;
   } ctrl_stat_type;

endpackage

[design/stbs_ctrl.sv]
// Controller state machine of the sorted table binary search block.
// Depends on stbs_pkg; drives stbs_dpath through the command struct.
module stbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  stbs_pkg::cmd_type      req_cmd,
   input  stbs_pkg::ctrl_stat_type stat,
   output stbs_pkg::ctrl_cmd_type ctl,
   output logic                   busy
);
   import stbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_cmd == CMD_SEARCH)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = stat.range_open ? ST_CMP : ST_IDLE;
         end
         ST_CMP: begin
            state_in = stat.key_eq ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            ctl.write_entry = start && (req_cmd == CMD_WRITE);
            ctl.load_search = start && (req_cmd == CMD_SEARCH);
         end
         ST_READ: begin
            ctl.issue_read = stat.range_open;
            ctl.emit_miss  = !stat.range_open;
         end
         ST_CMP: begin
            ctl.emit_hit = stat.key_eq;
            ctl.go_left  = stat.key_lt;
            ctl.go_right = !stat.key_eq && !stat.key_lt;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[design/stbs_dpath.sv]
// Datapath of the sorted table binary search block: table memory, bounds, result.
// Depends on stbs_pkg; steered by stbs_ctrl.
module stbs_dpath #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  stbs_pkg::req_type            req_data,
   input  logic                         csr_wr_en,
   input  logic [stbs_pkg::CNT_W-1:0]   csr_wr_data,
   input  stbs_pkg::ctrl_cmd_type       ctl,
   output stbs_pkg::ctrl_stat_type      stat,
   output logic                         rsp_valid,
   output stbs_pkg::rsp_type            rsp_data
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = $clog2(TABLE_DEPTH + 1);

   logic [VAL_W-1:0]  table_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]  entries_used_ff;
   logic [VAL_W-1:0]  key_ff;
   logic [NW-1:0]     low_ff;
   logic [NW-1:0]     hi_ex_ff;     // one past the last live entry
   logic [AW-1:0]     mid_ff;
   logic [VAL_W-1:0]  rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [NW-1:0]     count_in;
   logic [NW:0]       mid_sum;
   logic [AW-1:0]     mid_in;
   logic              wr_in_range;

   // Saturate the live count to the table size
   always_comb begin
      if (32'(entries_used_ff) > 32'(TABLE_DEPTH)) begin
         count_in = NW'(TABLE_DEPTH);
      end else begin
         count_in = NW'(entries_used_ff);
      end
   end

   // floor((low + high) / 2) with high = hi_ex - 1; only used while low < hi_ex
   assign mid_sum     = {1'b0, low_ff} + {1'b0, hi_ex_ff} - (NW+1)'(1);
   assign mid_in      = AW'(mid_sum >> 1);
   assign wr_in_range = 32'(req_data.write_index) < 32'(TABLE_DEPTH);

   assign stat.range_open = low_ff < hi_ex_ff;
   assign stat.key_lt     = $signed(key_ff) < $signed(rd_ff);
   assign stat.key_eq     = key_ff == rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_used_ff <= '0;
      end else if (csr_wr_en) begin
         entries_used_ff <= csr_wr_data;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.write_entry && wr_in_range) begin
         table_mem[AW'(req_data.write_index)] <= req_data.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue_read) begin
         rd_ff <= table_mem[mid_in];
      end
   end

   // Search bounds
   always_ff @(posedge clock) begin
      if (ctl.load_search) begin
         key_ff   <= req_data.search_key;
         low_ff   <= '0;
         hi_ex_ff <= count_in;
      end else begin
         if (ctl.go_left) begin
            hi_ex_ff <= NW'(mid_ff);
         end
         if (ctl.go_right) begin
            low_ff <= NW'(mid_ff) + NW'(1);
         end
      end
      if (ctl.issue_read) begin
         mid_ff <= mid_in;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit_hit || ctl.emit_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit_hit) begin
         rsp_ff.found       <= 1'b1;
         rsp_ff.match_index <= IDX_W'(mid_ff);
      end else if (ctl.emit_miss) begin
         rsp_ff.found       <= 1'b0;
         rsp_ff.match_index <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/sorted_table_binary_search_top.sv]
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_dpath.
//
// A word on req_data is taken at a rising edge where start is high and busy is low.
// A write word (cmd CMD_WRITE) stores entry_value at write_index; busy
// stays low, so another word may follow straight away, and an index beyond the table
// is dropped. A search word (cmd CMD_SEARCH) runs a two-test binary search over
// entries 0 to entries_used-1 (entries_used saturates at TABLE_DEPTH) and raises
// busy until its answer leaves. Each probe first issues the read of the table memory
// at the midpoint, then compares the registered entry with the key. A hit is
// registered onto rsp_valid from the compare of its last probe, a miss from the read
// state that finds the range empty; with 1024 entries a search makes at most 11
// probes, and an empty table gives a miss without a probe. The answer is on rsp_data
// for exactly one cycle, marked by rsp_valid; the receiver cannot hold it off, and
// busy is already low in that cycle, so the next word may be taken alongside it.
// The table has no reset: searching entries never written gives undefined answers.
// Write entries_used through csr_wr_en / csr_wr_data only while the block is idle.
module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  stbs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   output stbs_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [stbs_pkg::CNT_W-1:0]  csr_wr_data
);
   import stbs_pkg::*;

   ctrl_cmd_type  ctl;
   ctrl_stat_type stat;

   // Sequencer: idle, issue read, compare
   stbs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   // Table memory, search bounds, count register and result word
   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

[design/stbs_checker.sv]
// Port-level checks for the sorted table binary search block, bound to the top level.
// Depends on stbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stbs_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input stbs_pkg::req_type   req_data,
   input logic                rsp_valid,
   input stbs_pkg::rsp_type   rsp_data
);
   import stbs_pkg::*;

   `STBS_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   `STBS_ASSERT(a_write_silent, clock, reset, (start && !busy && req_data.cmd == CMD_WRITE) |=> !rsp_valid, "write word gave a result")
   `STBS_ASSERT(a_search_busy, clock, reset, (start && !busy && req_data.cmd == CMD_SEARCH) |=> busy, "search word did not raise busy")
   `STBS_NEVER(a_rsp_idle, clock, reset, rsp_valid && busy, "result shown while still busy")
   `STBS_ASSERT(a_miss_zero, clock, reset, (rsp_valid && !rsp_data.found) |-> (rsp_data.match_index == '0), "miss with non-zero index")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[tb/tb.sv]
// Self-checking bench for sorted_table_binary_search_top: directed table, then random words.
// Depends on stbs_pkg and the block's RTL; predicts answers with its own search model or pins them.
module tb;
   import stbs_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 500000;
   // A search probes at most 11 times.
   localparam int DRAIN_CYCLES = 30;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // Note kept per search word: either a pinned answer or "ask the model".
   typedef struct packed {
      logic    pinned;
      rsp_type want;
   } answer_note_type;

   // One row of the directed plan; set_cfg writes entries_used before the word.
   typedef struct {
      bit               set_cfg;
      logic [CNT_W-1:0] cfg;
      req_type          word;
      bit               pinned;
      rsp_type          want;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   // Model of the block, updated only from what crosses the ports, and the notes put_word queues.
   logic signed [VAL_W-1:0] model_table [DEPTH];
   logic [CNT_W-1:0]        model_count;
   rsp_type                 answers_due [$];
   answer_note_type         pinned_answers [$];

   // Stimulus side view of the table, kept apart from the model.
   logic signed [VAL_W-1:0] gen_table [DEPTH];
   int                      gen_count;
   int                      idle_pct;

   int fault_count;
   int cycle_count;

   sorted_table_binary_search_top #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // Two-test binary search over the model table, entries_used saturated at DEPTH.
   function automatic rsp_type search_table(input logic signed [VAL_W-1:0] key);
      int      n;
      int      lo;
      int      hi;
      int      mid;
      bit      done;
      rsp_type r;
      n = (model_count > DEPTH) ? DEPTH : int'(model_count);
      lo = 0;
      hi = n - 1;
      done = 0;
      r = '0;
      while (lo <= hi && !done) begin
         mid = (lo + hi) / 2;
         if (key < model_table[mid])
            hi = mid - 1;
         else if (key > model_table[mid])
            lo = mid + 1;
         else begin
            r.found = 1'b1;
            r.match_index = mid[IDX_W-1:0];
            done = 1;
         end
      end
      return r;
   endfunction

   // Port monitor: check answers first, then take the register write and the
   // accepted word, so a word taken alongside an answer lands behind it.
   always @(posedge clock) begin : watch_ports
      rsp_type         want;
      answer_note_type note;
      if (reset) begin
         model_count = '0;
         answers_due.delete();
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0)
               report_fault("answer word with nothing outstanding");
            else begin
               want = answers_due.pop_front();
               if (rsp_data.found !== want.found)
                  report_fault($sformatf("found: expected %0d, got %0d",
                                         want.found, rsp_data.found));
               if (rsp_data.match_index !== want.match_index)
                  report_fault($sformatf("match_index: expected %0d, got %0d",
                                         want.match_index, rsp_data.match_index));
            end
         end
         if (csr_wr_en)
            model_count = csr_wr_data;
         if (start && !busy) begin
            if (req_data.cmd == CMD_WRITE)
               model_table[req_data.write_index] = req_data.entry_value;
            else begin
               note = pinned_answers.pop_front();
               answers_due.push_back(note.pinned ? note.want
                                                 : search_table(req_data.search_key));
            end
         end
      end
   end

   // Offer one word and hold it until taken. Gaps drop start for a while first;
   // now and then a long one so that it lands deep inside a search.
   task automatic put_word(input req_type w, input bit pinned, input rsp_type want);
      answer_note_type note;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 24)) @(posedge clock);
         else
            repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      if (w.cmd == CMD_SEARCH) begin
         note.pinned = pinned;
         note.want = want;
         pinned_answers.push_back(note);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   // Wait until the block is idle and every answer is in, then write entries_used.
   task automatic set_entries(input int count);
      start <= 1'b0;
      @(negedge clock);
      while (answers_due.size() != 0 || busy) @(negedge clock);
      // A trailing write word leaves no answer behind: give it time to settle.
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(count);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gen_count = count;
   endtask

   function automatic plan_row_type plan_row(input bit set_cfg, input int cfg,
                                             input cmd_type cmd,
                                             input int idx, input int val, input int key,
                                             input bit pinned, input bit hit, input int at);
      plan_row_type r;
      r.set_cfg = set_cfg;
      r.cfg = CNT_W'(cfg);
      r.word.cmd = cmd;
      r.word.write_index = IDX_W'(idx);
      r.word.entry_value = val;
      r.word.search_key = key;
      r.pinned = pinned;
      r.want.found = hit;
      r.want.match_index = IDX_W'(at);
      return r;
   endfunction

   // Random word: mostly searches for keys that sit in or next to the table,
   // writes that keep their neighbours in order, and a little noise of both.
   task automatic random_word();
      req_type                 w;
      int                      eff;
      int                      sel;
      longint                  lo;
      longint                  hi;
      longint unsigned         pick;
      logic signed [VAL_W-1:0] key;
      w.write_index = IDX_W'($urandom_range(0, DEPTH - 1));
      w.entry_value = $urandom;
      w.search_key = $urandom;
      if ($urandom_range(0, 99) < 25) begin
         w.cmd = CMD_WRITE;
         if ($urandom_range(0, 9) != 0) begin
            lo = (w.write_index == 0) ? longint'(VAL_MIN)
                                      : longint'(gen_table[w.write_index - 1]);
            hi = (w.write_index == DEPTH - 1) ? longint'(VAL_MAX)
                                              : longint'(gen_table[w.write_index + 1]);
            pick = $urandom;
            if (hi < lo)
               w.entry_value = VAL_W'(lo);
            else
               w.entry_value = VAL_W'(lo + longint'(pick % $unsigned(hi - lo + 1)));
         end
         gen_table[w.write_index] = w.entry_value;
      end else begin
         w.cmd = CMD_SEARCH;
         eff = (gen_count > DEPTH) ? DEPTH : gen_count;
         sel = $urandom_range(0, 9);
         key = w.search_key;
         if (eff != 0 && sel < 5)
            key = gen_table[$urandom_range(0, eff - 1)];
         else if (eff != 0 && sel < 7)
            key = gen_table[$urandom_range(0, eff - 1)] + ($urandom_range(0, 1) ? 1 : -1);
         else if (sel == 7)
            key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
         w.search_key = key;
      end
      put_word(w, 1'b0, '0);
   endtask

   function automatic int block_count(input int blk);
      case (blk)
         0:       return DEPTH;
         1:       return 2047;
         2:       return 1;
         3:       return 0;
         4:       return 2;
         5:       return DEPTH - 1;
         6:       return $urandom_range(3, DEPTH);
         7:       return $urandom_range(DEPTH + 1, 2047);
         8:       return 3;
         9:       return $urandom_range(1, DEPTH);
         10:      return DEPTH;
         default: return 2047;
      endcase
   endfunction

   initial begin : stimulus
      plan_row_type plan [$];
      longint       acc;
      int           pct [3];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycle_count = 0;
      fault_count = 0;
      gen_count = 0;
      idle_pct = 0;
      pct = '{27, 61, 0};

      // Empty table first, then a tiny table holding both extremes, a
      // duplicate pair, and later an entry that breaks the order.
      plan.push_back(plan_row(1, 0, CMD_SEARCH, 0, 0, 0, 1, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, VAL_MIN, 1, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 0, VAL_MIN, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 1, -1, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 2, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 3, 5, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 4, 5, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 5, VAL_MAX, 0, 0, 0, 0));
      plan.push_back(plan_row(1, 6, CMD_SEARCH, 0, 0, VAL_MIN, 1, 1, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, VAL_MAX, 1, 1, 5));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, 5, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, 3, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, -1, 0, 0, 0));
      plan.push_back(plan_row(1, 1, CMD_SEARCH, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(1, 1, CMD_SEARCH, 0, 0, VAL_MIN, 1, 1, 0));
      plan.push_back(plan_row(0, 0, CMD_WRITE, 1, 100, 0, 0, 0, 0));
      plan.push_back(plan_row(1, 6, CMD_SEARCH, 0, 0, 100, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, 6, 0, 0, 0));
      plan.push_back(plan_row(0, 0, CMD_SEARCH, 0, 0, -5, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].set_cfg)
            set_entries(plan[i].cfg);
         put_word(plan[i].word, plan[i].pinned, plan[i].want);
      end

      // Fill every entry in ascending order, with some duplicates, so that any
      // entries_used reads only written entries from here on.
      acc = longint'(VAL_MIN);
      for (int i = 0; i < DEPTH; i++) begin
         gen_table[i] = (i == DEPTH - 1) ? VAL_MAX : VAL_W'(acc);
         put_word('{cmd: CMD_WRITE, write_index: IDX_W'(i), entry_value: gen_table[i],
                    search_key: $urandom}, 1'b0, '0);
         if ($urandom_range(0, 7) != 0)
            acc += $urandom_range(1, 8000000);
         if (acc > longint'(VAL_MAX))
            acc = longint'(VAL_MAX);
      end

      // Three idling regimes, four register settings in each.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = pct[phase];
         for (int blk = 0; blk < 4; blk++) begin
            set_entries(block_count(phase * 4 + blk));
            repeat (50) random_word();
         end
      end

      start <= 1'b0;
      @(negedge clock);
      while (answers_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0 && answers_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
